/* design/bpsa_pkg.sv */
// Shared types and constants for the block pool slot allocator.
package bpsa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int SLOTS_MAX  = 256;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SPB_W      = 9;
    localparam int REF_W      = 9;
    localparam int LIVE_W     = 15;

    localparam logic [SPB_W-1:0] SPB_RESET = SPB_W'(100);
    localparam logic [SPB_W-1:0] SPB_MAX   = SPB_W'(SLOTS_MAX);
    localparam logic [SPB_W-1:0] NEXT_FULL = '1;
    localparam logic [CNT_W-1:0] BLK_LIMIT = CNT_W'(MAX_BLOCKS);

    localparam logic CFG_SPB = 1'b0;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ALLOC     = 3'd0,
        ST_FREED     = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_NOT_OPEN  = 3'd3,
        ST_NO_LIVE   = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [5:0] target_block;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  got_block;
        logic [7:0]  got_slot;
        logic [14:0] live_count;
        logic [6:0]  opened_blocks;
    } rsp_t;

endpackage

/* design/bpsa_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module bpsa_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/block_pool_slot_allocator.sv */
// Top level: slot allocator over a pool of blocks with a free-block stack.
// An accepted request enters the execute state, which waits there while the output stalls.
// One transaction at a time: memory read on acceptance, then update and write back.
// A request is taken while a previous response still waits in the output register.
// Reset clears all control state; reference counts and stack entries are written before use.
module block_pool_slot_allocator
    import bpsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t             state_reg, state_next;
    logic [SPB_W-1:0]   spb_reg;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [BLK_W-1:0]   cur_reg, cur_next;
    logic [SPB_W-1:0]   next_slot_reg, next_slot_next;
    logic [LIVE_W-1:0]  live_reg, live_next;
    opcode_t            op_reg, op_next;
    logic [BLK_W-1:0]   fb_reg, fb_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               rd_en;
    logic [BLK_W-1:0]   ref_raddr;
    logic [REF_W-1:0]   ref_rdata;
    logic               ref_we;
    logic [BLK_W-1:0]   ref_waddr;
    logic [REF_W-1:0]   ref_wdata;
    logic [BLK_W-1:0]   stk_raddr;
    logic [BLK_W-1:0]   stk_rdata;
    logic               stk_we;
    logic [BLK_W-1:0]   stk_waddr;

    logic [SPB_W-1:0]   spb_eff;
    logic               full;
    logic               exhausted;
    logic [BLK_W-1:0]   alloc_blk;
    logic [SPB_W-1:0]   alloc_slot;
    logic               cfg_wr;

    // Config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == CFG_SPB);
    assign prdata = (paddr[2] == CFG_SPB) ? {{(32 - SPB_W){1'b0}}, spb_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= SPB_RESET;
        end
        else if (cfg_wr)
        begin
            spb_reg <= pwdata[SPB_W-1:0];
        end
    end

    assign spb_eff = (spb_reg == '0)     ? SPB_W'(1) :
                     (spb_reg > SPB_MAX) ? SPB_MAX   : spb_reg;
    assign full    = (next_slot_reg >= spb_eff) || ({1'b0, cur_reg} >= total_reg);

    assign rd_en     = (state_reg == S_IDLE) && req_valid;
    assign ref_raddr = (req.opcode == OP_FREE) ? req.target_block : cur_reg;
    assign stk_raddr = BLK_W'(depth_reg - CNT_W'(1));
    assign stk_waddr = depth_reg[BLK_W-1:0];

    bpsa_ram #(.ADDR_W(BLK_W), .DATA_W(REF_W)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (rd_en),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    bpsa_ram #(.ADDR_W(BLK_W), .DATA_W(BLK_W)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (fb_reg),
        .re    (rd_en),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        next_slot_next = next_slot_reg;
        live_next      = live_reg;
        op_next        = op_reg;
        fb_next        = fb_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rsp_next       = rsp_reg;
        ref_we         = 1'b0;
        ref_waddr      = fb_reg;
        ref_wdata      = ref_rdata;
        stk_we         = 1'b0;
        exhausted      = 1'b0;
        alloc_blk      = cur_reg;
        alloc_slot     = next_slot_reg;
        req_stall      = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    fb_next    = req.target_block;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (full)
                        begin
                            alloc_slot = '0;
                            if (depth_reg != '0)
                            begin
                                alloc_blk  = stk_rdata;
                                depth_next = depth_reg - CNT_W'(1);
                            end
                            else if (total_reg < BLK_LIMIT)
                            begin
                                alloc_blk  = total_reg[BLK_W-1:0];
                                total_next = total_reg + CNT_W'(1);
                            end
                            else
                            begin
                                exhausted = 1'b1;
                            end
                        end
                        if (exhausted)
                        begin
                            rsp_next.status = ST_EXHAUSTED;
                        end
                        else
                        begin
                            cur_next       = alloc_blk;
                            next_slot_next = alloc_slot + SPB_W'(1);
                            live_next      = live_reg + LIVE_W'(1);
                            ref_we         = 1'b1;
                            ref_waddr      = alloc_blk;
                            // a block taken from the stack or freshly opened holds no live slots
                            ref_wdata      = full ? REF_W'(1) : ref_rdata + REF_W'(1);
                            rsp_next.status    = ST_ALLOC;
                            rsp_next.got_block = alloc_blk;
                            rsp_next.got_slot  = alloc_slot[7:0];
                        end
                    end
                    else
                    begin
                        if ({1'b0, fb_reg} >= total_reg)
                        begin
                            rsp_next.status = ST_NOT_OPEN;
                        end
                        else if (ref_rdata == '0)
                        begin
                            rsp_next.status = ST_NO_LIVE;
                        end
                        else
                        begin
                            ref_we    = 1'b1;
                            ref_waddr = fb_reg;
                            ref_wdata = ref_rdata - REF_W'(1);
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - LIVE_W'(1);
                            end
                            if (ref_rdata == REF_W'(1))
                            begin
                                if (fb_reg == cur_reg)
                                begin
                                    next_slot_next = '0;
                                end
                                else if (depth_reg < BLK_LIMIT)
                                begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + CNT_W'(1);
                                end
                            end
                            rsp_next.status = ST_FREED;
                        end
                    end
                    rsp_next.live_count    = live_next;
                    rsp_next.opened_blocks = total_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            total_reg     <= '0;
            cur_reg       <= '0;
            next_slot_reg <= NEXT_FULL;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            next_slot_reg <= next_slot_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        fb_reg  <= fb_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= BLK_LIMIT)
        else $error("free stack depth past pool size");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= BLK_LIMIT)
        else $error("opened block count past pool size");

    a_cur_opened: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> ({1'b0, cur_reg} < total_reg))
        else $error("current block not opened");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

endmodule
